[sv/m3i_pkg.sv]
// Package: shared types, widths and cofactor index tables for the 3x3 inverse core.
`default_nettype none
package m3i_pkg;

   localparam int unsigned ENTRY_W = 16;
   localparam int unsigned RES_W   = 32;
   localparam int unsigned PROD_W  = 2 * ENTRY_W;        // 32
   localparam int unsigned COF_W   = PROD_W + 1;         // 33
   localparam int unsigned DPROD_W = ENTRY_W + COF_W;    // 49
   localparam int unsigned DET_W   = DPROD_W + 1;        // 50
   localparam int unsigned DMAG_W  = 48;                 // |det| < 2^48
   localparam int unsigned QUO_W   = 33;                 // quotient bits per lane
   localparam int unsigned LANE_LAT = QUO_W + 2;         // setup, steps, saturate
   localparam int unsigned N_ENTRY = 9;
   localparam int unsigned N_PROD  = 18;

   // cofactor k = prod[2k] - prod[2k+1], prod[j] = m[PROD_A[j]] * m[PROD_B[j]]
   localparam int unsigned PROD_A [N_PROD] =
      '{4, 7, 7, 1, 1, 4, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
   localparam int unsigned PROD_B [N_PROD] =
      '{8, 5, 2, 8, 5, 2, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

   typedef struct packed {
      logic signed [ENTRY_W-1:0] a00;
      logic signed [ENTRY_W-1:0] a01;
      logic signed [ENTRY_W-1:0] a02;
      logic signed [ENTRY_W-1:0] a10;
      logic signed [ENTRY_W-1:0] a11;
      logic signed [ENTRY_W-1:0] a12;
      logic signed [ENTRY_W-1:0] a20;
      logic signed [ENTRY_W-1:0] a21;
      logic signed [ENTRY_W-1:0] a22;
   } req_data_type;

   typedef struct packed {
      logic signed [RES_W-1:0] b00;
      logic signed [RES_W-1:0] b01;
      logic signed [RES_W-1:0] b02;
      logic signed [RES_W-1:0] b10;
      logic signed [RES_W-1:0] b11;
      logic signed [RES_W-1:0] b12;
      logic signed [RES_W-1:0] b20;
      logic signed [RES_W-1:0] b21;
      logic signed [RES_W-1:0] b22;
      logic                    singular;
   } rsp_data_type;

   typedef logic [N_ENTRY-1:0][ENTRY_W-1:0] mat_type;

   typedef struct packed {
      logic    singular;
      mat_type mat;
   } side_type;

endpackage
`default_nettype wire

[sv/m3i_chan_if.sv]
// Interfaces: valid/ready channels for the matrix and inverse items.
`default_nettype none
interface m3i_req_if;
   import m3i_pkg::*;
   logic         valid;
   logic         ready;
   req_data_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface m3i_rsp_if;
   import m3i_pkg::*;
   logic         valid;
   logic         ready;
   rsp_data_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/matrix3x3_inverse_core.sv]
// Throughput: one matrix per cycle; each of the nine divider lanes produces one
// quotient bit per stage over 33 stages, and the whole pipeline holds on a stall.
// Reset clears the valid bits of every stage; data registers keep their contents.
// Top level: 3x3 matrix inverse by adjugate and pipelined restoring division.
`default_nettype none
module matrix3x3_inverse_core (
   input  wire logic clock,
   input  wire logic reset,
   m3i_req_if.sink   req_chan,
   m3i_rsp_if.source rsp_chan
);
   import m3i_pkg::*;

   logic advance;
   logic signed [ENTRY_W-1:0] in_m [N_ENTRY];

   logic                      vld_ff [4];
   mat_type                   mat_ff [4];
   logic signed [PROD_W-1:0]  prod_ff [N_PROD];
   logic signed [COF_W-1:0]   cof2_ff [N_ENTRY];
   logic signed [COF_W-1:0]   cof3_ff [N_ENTRY];
   logic signed [COF_W-1:0]   cof4_ff [N_ENTRY];
   logic signed [DPROD_W-1:0] dprod_ff [3];
   logic signed [DET_W-1:0]   det_ff;

   logic     dly_vld_ff  [LANE_LAT];
   side_type dly_side_ff [LANE_LAT];
   logic signed [RES_W-1:0] lane_res [N_ENTRY];
   side_type out_side;

   assign advance        = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_comb begin
      in_m[0] = req_chan.data.a00;
      in_m[1] = req_chan.data.a01;
      in_m[2] = req_chan.data.a02;
      in_m[3] = req_chan.data.a10;
      in_m[4] = req_chan.data.a11;
      in_m[5] = req_chan.data.a12;
      in_m[6] = req_chan.data.a20;
      in_m[7] = req_chan.data.a21;
      in_m[8] = req_chan.data.a22;
   end

   // carry valid bits; clear on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 4; s++) vld_ff[s] <= 1'b0;
         for (int s = 0; s < int'(LANE_LAT); s++) dly_vld_ff[s] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_chan.valid;
         for (int s = 1; s < 4; s++) vld_ff[s] <= vld_ff[s-1];
         dly_vld_ff[0] <= vld_ff[3];
         for (int s = 1; s < int'(LANE_LAT); s++) dly_vld_ff[s] <= dly_vld_ff[s-1];
      end
   end

   // products, cofactors, determinant terms, determinant
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < int'(N_PROD); k++)
            prod_ff[k] <= in_m[PROD_A[k]] * in_m[PROD_B[k]];
         for (int e = 0; e < int'(N_ENTRY); e++)
            mat_ff[0][e] <= in_m[e];
         for (int s = 1; s < 4; s++) mat_ff[s] <= mat_ff[s-1];

         for (int c = 0; c < int'(N_ENTRY); c++)
            cof2_ff[c] <= $signed({prod_ff[2*c][PROD_W-1], prod_ff[2*c]})
                        - $signed({prod_ff[2*c+1][PROD_W-1], prod_ff[2*c+1]});

         for (int j = 0; j < 3; j++)
            dprod_ff[j] <= $signed(mat_ff[1][3*j]) * cof2_ff[j];
         cof3_ff <= cof2_ff;

         det_ff <= $signed({dprod_ff[0][DPROD_W-1], dprod_ff[0]})
                 + $signed({dprod_ff[1][DPROD_W-1], dprod_ff[1]})
                 + $signed({dprod_ff[2][DPROD_W-1], dprod_ff[2]});
         cof4_ff <= cof3_ff;

         dly_side_ff[0] <= '{singular: (det_ff == '0), mat: mat_ff[3]};
         for (int s = 1; s < int'(LANE_LAT); s++) dly_side_ff[s] <= dly_side_ff[s-1];
      end
   end

   for (genvar g = 0; g < int'(N_ENTRY); g++) begin : g_lane
      m3i_div_lane u_lane (
         .clock   (clock),
         .advance (advance),
         .cof     (cof4_ff[g]),
         .det     (det_ff),
         .res     (lane_res[g])
      );
   end

   assign out_side = dly_side_ff[LANE_LAT-1];

   // pick quotient or input entry shifted left by two and sign-extended
   function automatic logic signed [RES_W-1:0] pick(input logic sing,
                                                     input logic [ENTRY_W-1:0] a,
                                                     input logic signed [RES_W-1:0] q);
      logic signed [RES_W-1:0] w;
      w = RES_W'($signed({a, 2'b00}));
      return sing ? w : q;
   endfunction

   assign rsp_chan.valid         = dly_vld_ff[LANE_LAT-1];
   assign rsp_chan.data.singular = out_side.singular;
   assign rsp_chan.data.b00 = pick(out_side.singular, out_side.mat[0], lane_res[0]);
   assign rsp_chan.data.b01 = pick(out_side.singular, out_side.mat[1], lane_res[1]);
   assign rsp_chan.data.b02 = pick(out_side.singular, out_side.mat[2], lane_res[2]);
   assign rsp_chan.data.b10 = pick(out_side.singular, out_side.mat[3], lane_res[3]);
   assign rsp_chan.data.b11 = pick(out_side.singular, out_side.mat[4], lane_res[4]);
   assign rsp_chan.data.b12 = pick(out_side.singular, out_side.mat[5], lane_res[5]);
   assign rsp_chan.data.b20 = pick(out_side.singular, out_side.mat[6], lane_res[6]);
   assign rsp_chan.data.b21 = pick(out_side.singular, out_side.mat[7], lane_res[7]);
   assign rsp_chan.data.b22 = pick(out_side.singular, out_side.mat[8], lane_res[8]);

   // an accepted item shows up in the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> vld_ff[0])
      else $error("accepted item not captured");

   // a held result keeps its valid and singular flag
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid && $stable(out_side.singular))
      else $error("stalled result changed");

   // a stall freezes the determinant stage
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff[3]) && $stable(det_ff))
      else $error("pipeline moved during stall");

endmodule
`default_nettype wire

[sv/m3i_div_lane.sv]
// Divider lane: pipelined restoring division cof*2^30/det, truncated and saturated.
`default_nettype none
module m3i_div_lane (
   input  wire logic                                clock,
   input  wire logic                                advance,
   input  wire logic signed [m3i_pkg::COF_W-1:0]    cof,
   input  wire logic signed [m3i_pkg::DET_W-1:0]    det,
   output logic signed [m3i_pkg::RES_W-1:0]         res
);
   import m3i_pkg::*;

   localparam int unsigned NST = QUO_W + 1;

   logic [DMAG_W-1:0] rem_ff [NST];
   logic [DMAG_W-1:0] d_ff   [NST];
   logic [QUO_W-1:0]  q_ff   [NST];
   logic [2:0]        low_ff [NST];
   logic              ovf_ff [NST];
   logic              neg_ff [NST];
   logic [DMAG_W-1:0] rem_in [QUO_W];
   logic [QUO_W-1:0]  q_in   [QUO_W];
   logic signed [RES_W-1:0] res_ff;
   logic signed [RES_W-1:0] res_in;

   logic [COF_W-1:0] cabs;
   logic [DET_W-1:0] dabs;

   // take magnitudes; the setup stage splits the shifted numerator and checks range up front
   always_comb begin
      cabs = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
      dabs = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
   end

   // one quotient bit per stage
   always_comb begin
      logic [DMAG_W:0] r2;
      logic            nbit;
      logic            ge;
      r2   = '0;
      nbit = 1'b0;
      ge   = 1'b0;
      for (int i = 0; i < int'(QUO_W); i++) begin
         nbit = (i < 3) ? low_ff[i][2-i] : 1'b0;
         r2   = {rem_ff[i], nbit};
         ge   = (r2 >= {1'b0, d_ff[i]});
         rem_in[i] = ge ? DMAG_W'(r2 - {1'b0, d_ff[i]}) : r2[DMAG_W-1:0];
         q_in[i]   = {q_ff[i][QUO_W-2:0], ge};
      end
   end

   // saturate to the signed 32-bit range with the quotient's sign
   always_comb begin
      logic [QUO_W-1:0] q;
      q = q_ff[NST-1];
      if (!neg_ff[NST-1]) begin
         if (ovf_ff[NST-1] || q[QUO_W-1] || q[RES_W-1])
            res_in = {1'b0, {(RES_W-1){1'b1}}};
         else
            res_in = $signed(q[RES_W-1:0]);
      end else begin
         if (ovf_ff[NST-1] || q[QUO_W-1] || (q[RES_W-1] && (|q[RES_W-2:0])))
            res_in = {1'b1, {(RES_W-1){1'b0}}};
         else
            res_in = $signed(RES_W'(-q[RES_W-1:0]));
      end
   end

   // advance the lane as one with the rest of the pipeline
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= DMAG_W'(cabs[COF_W-2:3]);
         d_ff[0]   <= dabs[DMAG_W-1:0];
         q_ff[0]   <= '0;
         low_ff[0] <= cabs[2:0];
         ovf_ff[0] <= (DET_W'(cabs[COF_W-2:3]) >= dabs);
         neg_ff[0] <= cof[COF_W-1] ^ det[DET_W-1];
         for (int i = 0; i < int'(QUO_W); i++) begin
            rem_ff[i+1] <= rem_in[i];
            d_ff[i+1]   <= d_ff[i];
            q_ff[i+1]   <= q_in[i];
            low_ff[i+1] <= low_ff[i];
            ovf_ff[i+1] <= ovf_ff[i];
            neg_ff[i+1] <= neg_ff[i];
         end
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule
`default_nettype wire
